>>> sv/bsa_pkg.sv
package bsa_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_USED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_GRANT,
    ST_FREE
  } ctl_state_e;

  typedef enum logic [1:0] {
    PICK_DONE,
    PICK_GRANT,
    PICK_FREE
  } pick_next_e;

  typedef struct packed {
    logic accept;
    logic pick;
    logic grant;
    logic free;
  } cmd_t;

  typedef struct packed {
    pick_next_e pick_next;
    logic       retry;
    logic       out_free;
  } sts_t;

endpackage

>>> sv/bsa_ctrl.sv
module bsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  bsa_pkg::sts_t sts_i,
  output bsa_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  bsa_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Every working step waits while the output register still holds an
  // untaken result, so no state change happens before its result can land.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bsa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bsa_pkg::ST_PICK;
        end
      end
      bsa_pkg::ST_PICK: begin
        if (sts_i.out_free) begin
          cmd_o.pick = 1'b1;
          case (sts_i.pick_next)
            bsa_pkg::PICK_GRANT: state_d = bsa_pkg::ST_GRANT;
            bsa_pkg::PICK_FREE:  state_d = bsa_pkg::ST_FREE;
            default:             state_d = bsa_pkg::ST_IDLE;
          endcase
        end
      end
      bsa_pkg::ST_GRANT: begin
        if (sts_i.out_free) begin
          cmd_o.grant = 1'b1;
          state_d     = sts_i.retry ? bsa_pkg::ST_PICK : bsa_pkg::ST_IDLE;
        end
      end
      bsa_pkg::ST_FREE: begin
        if (sts_i.out_free) begin
          cmd_o.free = 1'b1;
          state_d    = bsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/bsa_datapath.sv
module bsa_datapath #(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bsa_pkg::ACTION_W-1:0]   in_action_i,
  input  logic [bsa_pkg::INDEX_W-1:0]    in_slot_index_i,
  input  logic                           cfg_we_i,
  input  logic [bsa_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  bsa_pkg::cmd_t                  cmd_i,
  output bsa_pkg::sts_t                  sts_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [bsa_pkg::STATUS_W-1:0]   out_status_o,
  output logic [bsa_pkg::INDEX_W-1:0]    out_granted_slot_o,
  output logic [bsa_pkg::COUNT_W-1:0]    out_used_count_o,
  output logic                           out_is_full_o,
  output logic                           out_is_empty_o
);

  localparam int unsigned NWORDS    = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned HINT_W    = $clog2(NWORDS + 1);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned SPAN_W    = $clog2(NWORDS * WORD_BITS + 1);
  localparam int unsigned VAL_W     = (SPAN_W > bsa_pkg::LIMIT_W) ? SPAN_W : bsa_pkg::LIMIT_W;

  // Used-bit map, one flop word per map word.
  logic [WORD_BITS-1:0]          map_q [NWORDS];
  logic [bsa_pkg::LIMIT_W-1:0]   limit_q;
  logic [HINT_W-1:0]             hint_q, hint_d;
  logic [VAL_W-1:0]              total_q, total_d;
  logic                          from_hint_q;
  logic                          out_valid_q;

  logic [bsa_pkg::ACTION_W-1:0]  act_q;
  logic [bsa_pkg::INDEX_W-1:0]   idx_q;
  logic [WORD_BITS-1:0]          word_q;
  logic [WIDX_W-1:0]             wsel_q;
  logic [BIT_W-1:0]              bsel_q;

  logic [bsa_pkg::STATUS_W-1:0]  out_status_q;
  logic [bsa_pkg::INDEX_W-1:0]   out_slot_q;
  logic [bsa_pkg::COUNT_W-1:0]   out_count_q;
  logic                          out_full_q;
  logic                          out_empty_q;

  logic [VAL_W-1:0]              lim;
  logic [VAL_W-1:0]              idx_ext;
  logic [NWORDS-1:0]             word_live;
  logic [NWORDS-1:0]             word_full;
  logic [NWORDS-1:0]             word_b0;

  logic                          hint_on;
  logic [HINT_W-1:0]             hint_w_wide;
  logic [WIDX_W-1:0]             hint_w;
  logic                          hint_live;

  logic                          scan_hit;
  logic [WIDX_W-1:0]             scan_w;

  logic [WIDX_W-1:0]             rel_w;
  logic [VAL_W-1:0]              rel_base;
  logic [VAL_W-1:0]              rel_off;
  logic [BIT_W-1:0]              rel_b;

  bsa_pkg::pick_next_e           pick_next;
  logic [bsa_pkg::STATUS_W-1:0]  pick_status;
  logic                          pick_hint_clear;
  logic                          pick_from_hint;
  logic [WIDX_W-1:0]             rd_w;

  logic [BIT_W-1:0]              lz;
  logic [VAL_W-1:0]              grant_base;
  logic [VAL_W-1:0]              grant_slot;
  logic                          grant_miss;
  logic [WORD_BITS-1:0]          new_word;
  logic                          new_full;
  logic [WIDX_W:0]               nxt_w;
  logic                          nxt_free;
  logic                          last_bit;
  logic [WORD_BITS-1:0]          freed_word;

  logic                          map_we;
  logic                          map_clr;
  logic [WORD_BITS-1:0]          map_wdata;
  logic                          finish;
  logic [bsa_pkg::STATUS_W-1:0]  res_status;
  logic [VAL_W-1:0]              res_slot;

  assign lim     = (VAL_W'(limit_q) > VAL_W'(SLOTS)) ? VAL_W'(SLOTS) : VAL_W'(limit_q);
  assign idx_ext = VAL_W'(idx_q);

  // A word takes part only when it covers at least one slot below the limit.
  always_comb begin
    for (int w = 0; w < NWORDS; w++) begin
      word_live[w] = VAL_W'(w * WORD_BITS) < lim;
      word_full[w] = &map_q[w];
      word_b0[w]   = map_q[w][0];
    end
  end

  assign hint_on     = hint_q != '0;
  assign hint_w_wide = hint_q - HINT_W'(1);
  assign hint_w      = hint_w_wide[WIDX_W-1:0];
  assign hint_live   = hint_on && (hint_w_wide < HINT_W'(NWORDS)) && word_live[hint_w];

  always_comb begin
    scan_hit = 1'b0;
    scan_w   = '0;
    for (int w = NWORDS - 1; w >= 0; w--) begin
      if (word_live[w] && !word_full[w]) begin
        scan_hit = 1'b1;
        scan_w   = WIDX_W'(w);
      end
    end
  end

  // Word and bit of the slot to release, found by comparing against the
  // word boundaries.
  always_comb begin
    rel_w    = '0;
    rel_base = '0;
    for (int k = 1; k < NWORDS; k++) begin
      if (idx_ext >= VAL_W'(k * WORD_BITS)) begin
        rel_w    = WIDX_W'(k);
        rel_base = VAL_W'(k * WORD_BITS);
      end
    end
  end

  assign rel_off = idx_ext - rel_base;
  assign rel_b   = rel_off[BIT_W-1:0];

  always_comb begin
    pick_next       = bsa_pkg::PICK_DONE;
    pick_status     = bsa_pkg::STS_OK;
    pick_hint_clear = 1'b0;
    pick_from_hint  = 1'b0;
    rd_w            = scan_w;
    case (act_q)
      bsa_pkg::ACT_ALLOC: begin
        if (total_q >= lim) begin
          pick_status = bsa_pkg::STS_NO_FREE;
        end else if (hint_live && !word_full[hint_w]) begin
          pick_next      = bsa_pkg::PICK_GRANT;
          pick_from_hint = 1'b1;
          rd_w           = hint_w;
        end else begin
          // A full hinted word keeps its hint; a hint beyond the limit is dropped.
          pick_hint_clear = hint_on && !hint_live;
          if (scan_hit) begin
            pick_next = bsa_pkg::PICK_GRANT;
          end else begin
            pick_status = bsa_pkg::STS_NO_FREE;
          end
        end
      end
      bsa_pkg::ACT_FREE: begin
        if (idx_ext >= lim) begin
          pick_status = bsa_pkg::STS_RANGE;
        end else begin
          pick_next = bsa_pkg::PICK_FREE;
          rd_w      = rel_w;
        end
      end
      default: begin
        pick_next = bsa_pkg::PICK_DONE;
      end
    endcase
  end

  always_comb begin
    lz = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word_q[b]) begin
        lz = BIT_W'(b);
      end
    end
  end

  assign grant_base = VAL_W'(wsel_q) * VAL_W'(WORD_BITS);
  assign grant_slot = grant_base + VAL_W'(lz);
  assign grant_miss = grant_slot >= lim;
  assign new_word   = word_q | (WORD_BITS'(1) << lz);
  assign new_full   = &new_word;
  assign last_bit   = lz == BIT_W'(WORD_BITS - 1);
  assign nxt_w      = {1'b0, wsel_q} + (WIDX_W + 1)'(1);
  assign nxt_free   = (nxt_w < (WIDX_W + 1)'(NWORDS)) && !word_b0[nxt_w[WIDX_W-1:0]];
  assign freed_word = word_q & ~(WORD_BITS'(1) << bsel_q);

  always_comb begin
    hint_d     = hint_q;
    total_d    = total_q;
    map_we     = 1'b0;
    map_clr    = 1'b0;
    map_wdata  = new_word;
    finish     = 1'b0;
    res_status = bsa_pkg::STS_OK;
    res_slot   = '0;
    if (cmd_i.pick) begin
      if (pick_hint_clear) begin
        hint_d = '0;
      end
      if (pick_next == bsa_pkg::PICK_DONE) begin
        finish     = 1'b1;
        res_status = pick_status;
        if (act_q == bsa_pkg::ACT_CLEAR) begin
          map_clr = 1'b1;
          total_d = '0;
          hint_d  = HINT_W'(1);
        end
      end
    end
    if (cmd_i.grant) begin
      if (grant_miss) begin
        if (from_hint_q) begin
          hint_d = '0;
        end else begin
          finish     = 1'b1;
          res_status = bsa_pkg::STS_NO_FREE;
        end
      end else begin
        map_we    = 1'b1;
        map_wdata = new_word;
        total_d   = total_q + VAL_W'(1);
        finish    = 1'b1;
        res_slot  = grant_slot;
        if (from_hint_q) begin
          // Once the hinted word fills, the hint moves on only when the very
          // next slot sits at the start of the following word and is free.
          if (new_full) begin
            if (last_bit && ((grant_slot + VAL_W'(1)) < lim) && nxt_free) begin
              hint_d = HINT_W'(nxt_w) + HINT_W'(1);
            end else begin
              hint_d = '0;
            end
          end
        end else if (!new_full) begin
          hint_d = HINT_W'(wsel_q) + HINT_W'(1);
        end
      end
    end
    if (cmd_i.free) begin
      finish = 1'b1;
      if ((total_q == '0) || !word_q[bsel_q]) begin
        res_status = bsa_pkg::STS_NOT_USED;
      end else begin
        map_we    = 1'b1;
        map_wdata = freed_word;
        total_d   = total_q - VAL_W'(1);
        if (!hint_on) begin
          hint_d = HINT_W'(wsel_q) + HINT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= bsa_pkg::LIMIT_RESET;
      hint_q      <= HINT_W'(1);
      total_q     <= '0;
      from_hint_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int w = 0; w < NWORDS; w++) begin
        map_q[w] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      hint_q  <= hint_d;
      total_q <= total_d;
      if (cmd_i.pick) begin
        from_hint_q <= pick_from_hint;
      end
      for (int w = 0; w < NWORDS; w++) begin
        if (map_clr) begin
          map_q[w] <= '0;
        end else if (map_we && (wsel_q == WIDX_W'(w))) begin
          map_q[w] <= map_wdata;
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= in_action_i;
      idx_q <= in_slot_index_i;
    end
    if (cmd_i.pick) begin
      word_q <= map_q[rd_w];
      wsel_q <= rd_w;
      bsel_q <= rel_b;
    end
    if (finish) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot[bsa_pkg::INDEX_W-1:0];
      out_count_q  <= total_d[bsa_pkg::COUNT_W-1:0];
      out_full_q   <= total_d == lim;
      out_empty_q  <= total_d == '0;
    end
  end

  assign sts_o.pick_next = pick_next;
  assign sts_o.retry     = from_hint_q && grant_miss;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_granted_slot_o = out_slot_q;
  assign out_used_count_o   = out_count_q;
  assign out_is_full_o      = out_full_q;
  assign out_is_empty_o     = out_empty_q;

endmodule

>>> sv/bitmap_slot_allocator_core.sv
// Fixed-slot allocator over a used-bit map held in WORD_BITS-wide flop words.
// Each transaction is accepted in the idle state and then runs alone: a pick
// step picks the map word (the hinted word, else the first word with a free
// slot) and registers it; for an allocate a grant step then finds its lowest
// free bit with a priority encoder and writes the word back, and for a
// release a free step clears the slot's bit. An allocate whose hint misses
// late goes back to the pick step and scans; a clear, an allocate refused at
// once, an out-of-range release or an unused action finishes in the pick step.
// The result lands in an output register, so the next transaction is taken
// while an earlier result still waits; every later step holds for as long as
// that earlier result is still untaken.
module bitmap_slot_allocator_core #(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bsa_pkg::ACTION_W-1:0]   in_action_i,
  input  logic [bsa_pkg::INDEX_W-1:0]    in_slot_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bsa_pkg::STATUS_W-1:0]   out_status_o,
  output logic [bsa_pkg::INDEX_W-1:0]    out_granted_slot_o,
  output logic [bsa_pkg::COUNT_W-1:0]    out_used_count_o,
  output logic                           out_is_full_o,
  output logic                           out_is_empty_o,
  input  logic                           cfg_we_i,
  input  logic [bsa_pkg::LIMIT_W-1:0]    cfg_wdata_i
);

  bsa_pkg::cmd_t cmd;
  bsa_pkg::sts_t sts;

  bsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  bsa_datapath #(
    .SLOTS     (SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_action_i        (in_action_i),
    .in_slot_index_i    (in_slot_index_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_status_o       (out_status_o),
    .out_granted_slot_o (out_granted_slot_o),
    .out_used_count_o   (out_used_count_o),
    .out_is_full_o      (out_is_full_o),
    .out_is_empty_o     (out_is_empty_o)
  );

  // The controller issues at most one step per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.pick, cmd.grant, cmd.free}))
    else $error("more than one datapath step issued in a cycle");

  // A new transaction is never taken while one is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after a transaction was accepted");

  // Only a successful allocate reports a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o != bsa_pkg::STS_OK)) |-> (out_granted_slot_o == '0))
    else $error("failed request reports a granted slot");

endmodule
